// ----- design/vfcm_pkg.sv -----
// Shared types and codes for the voxel face-culling mesher.
// Used by vfcm_scan, vfcm_emit and the top level; no dependencies.
`default_nettype none

package vfcm_pkg;

    // Input item operations
    localparam logic [1:0] FUNC_STORE_VOXEL  = 2'd0;
    localparam logic [1:0] FUNC_STORE_BORDER = 2'd1;
    localparam logic [1:0] FUNC_EXAMINE      = 2'd2;

    // Border sides of the neighbor chunks
    localparam logic [1:0] SIDE_WEST  = 2'd0;
    localparam logic [1:0] SIDE_EAST  = 2'd1;
    localparam logic [1:0] SIDE_NORTH = 2'd2;
    localparam logic [1:0] SIDE_SOUTH = 2'd3;

    // Face directions, in emission order
    localparam logic [2:0] DIR_WEST   = 3'd0;
    localparam logic [2:0] DIR_EAST   = 3'd1;
    localparam logic [2:0] DIR_NORTH  = 3'd2;
    localparam logic [2:0] DIR_SOUTH  = 3'd3;
    localparam logic [2:0] DIR_BOTTOM = 3'd4;
    localparam logic [2:0] DIR_TOP    = 3'd5;
    localparam int         NUM_DIRS   = 6;

    // Configuration register indexes
    localparam logic [1:0] REG_CHUNK_X    = 2'd0;
    localparam logic [1:0] REG_CHUNK_Z    = 2'd1;
    localparam logic [1:0] REG_HALF_WORLD = 2'd2;

    localparam logic [6:0] HALF_WORLD_RESET = 7'd8;
    localparam logic [19:0] VERTEX_STEP     = 20'd4;

    typedef struct packed {
        logic signed [6:0] chunk_x;
        logic signed [6:0] chunk_z;
        logic [6:0]        half_world;
    } vfcm_cfg_t;

    // Examined voxel handed from the fetch sequencer to the face emitter
    typedef struct packed {
        logic                start;
        logic [NUM_DIRS-1:0] mask;
        logic [7:0]          id;
        logic [3:0]          x;
        logic [6:0]          y;
        logic [3:0]          z;
    } vfcm_job_t;

endpackage

`default_nettype wire

// ----- design/vfcm_if.sv -----
// Valid/ready channel interfaces: command beats in, face beats out.
// No dependencies.
`default_nettype none

interface vfcm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] local_x;
    logic [6:0] local_y;
    logic [3:0] local_z;
    logic [1:0] border_side;
    logic [7:0] voxel_value;

    modport source (output valid, func, local_x, local_y, local_z, border_side, voxel_value,
                    input ready);
    modport sink (input valid, func, local_x, local_y, local_z, border_side, voxel_value,
                  output ready);
endinterface

interface vfcm_face_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] world_x;
    logic [6:0]         world_y;
    logic signed [10:0] world_z;
    logic [2:0]         face_dir;
    logic [7:0]         face_voxel_id;
    logic [19:0]        first_vertex;
    logic               last;

    modport source (output valid, world_x, world_y, world_z, face_dir, face_voxel_id,
                    first_vertex, last, input ready);
    modport sink (input valid, world_x, world_y, world_z, face_dir, face_voxel_id,
                  first_vertex, last, output ready);
endinterface

`default_nettype wire

// ----- design/vfcm_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module vfcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/vfcm_scan.sv -----
// Fetch sequencer: takes command beats, writes the voxel and border memories,
// and for an examined voxel reads it and its six neighbors to build a face mask.
// Depends on vfcm_pkg and vfcm_if.
`default_nettype none

module vfcm_scan #(
    parameter int CHUNK_W = 16,
    parameter int CHUNK_H = 128
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    vfcm_cmd_if.sink                    cmd,
    input  wire vfcm_pkg::vfcm_cfg_t    cfg,
    // voxel memory
    output logic                        vox_we,
    output logic [$clog2(CHUNK_W*CHUNK_H*CHUNK_W)-1:0] vox_waddr,
    output logic [7:0]                  vox_wdata,
    output logic [$clog2(CHUNK_W*CHUNK_H*CHUNK_W)-1:0] vox_raddr,
    input  wire logic [7:0]             vox_rdata,
    // border memory
    output logic                        brd_we,
    output logic [$clog2(4*CHUNK_H*CHUNK_W)-1:0] brd_waddr,
    output logic                        brd_wdata,
    output logic [$clog2(4*CHUNK_H*CHUNK_W)-1:0] brd_raddr,
    input  wire logic                   brd_rdata,
    // hand-off to the emitter
    output vfcm_pkg::vfcm_job_t         job,
    input  wire logic                   emit_idle
);

    localparam int VAW = $clog2(CHUNK_W*CHUNK_H*CHUNK_W);
    localparam int BAW = $clog2(4*CHUNK_H*CHUNK_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_HAND = 2'd2;

    // Read steps: center, then one per direction, then a drain step
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_WEST   = 3'd1;
    localparam logic [2:0] STEP_EAST   = 3'd2;
    localparam logic [2:0] STEP_NORTH  = 3'd3;
    localparam logic [2:0] STEP_SOUTH  = 3'd4;
    localparam logic [2:0] STEP_BOTTOM = 3'd5;
    localparam logic [2:0] STEP_TOP    = 3'd6;
    localparam logic [2:0] STEP_DRAIN  = 3'd7;

    function automatic logic [VAW-1:0] vox_addr(input int x, input int y, input int z);
        int a;
        a = (x * CHUNK_H + y) * CHUNK_W + z;
        return a[VAW-1:0];
    endfunction

    function automatic logic [BAW-1:0] brd_addr(input int side, input int y, input int pos);
        int a;
        a = (side * CHUNK_H + y) * CHUNK_W + pos;
        return a[BAW-1:0];
    endfunction

    logic [1:0]  state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic [3:0]  x_reg, x_next;
    logic [6:0]  y_reg, y_next;
    logic [3:0]  z_reg, z_next;
    logic [7:0]  id_reg, id_next;
    logic [vfcm_pkg::NUM_DIRS-1:0] mask_reg, mask_next;

    logic        accept;
    logic        in_range;
    logic [3:0]  brd_pos;
    logic        brd_in_range;
    logic        x_lo, x_hi, z_lo, z_hi, y_lo, y_hi;
    logic        west_ok, east_ok, north_ok, south_ok;
    logic [2:0]  dir;
    logic        face_bit;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    // Store path: writes happen on the accepting edge
    assign in_range = (int'(cmd.local_x) < CHUNK_W) && (int'(cmd.local_y) < CHUNK_H)
                      && (int'(cmd.local_z) < CHUNK_W);
    assign brd_pos  = (cmd.border_side inside {vfcm_pkg::SIDE_WEST, vfcm_pkg::SIDE_EAST})
                      ? cmd.local_z : cmd.local_x;
    assign brd_in_range = (int'(cmd.local_y) < CHUNK_H) && (int'(brd_pos) < CHUNK_W);

    assign vox_we    = accept && (cmd.func == vfcm_pkg::FUNC_STORE_VOXEL) && in_range;
    assign vox_waddr = vox_addr(int'(cmd.local_x), int'(cmd.local_y), int'(cmd.local_z));
    assign vox_wdata = cmd.voxel_value;
    assign brd_we    = accept && (cmd.func == vfcm_pkg::FUNC_STORE_BORDER) && brd_in_range;
    assign brd_waddr = brd_addr(int'(cmd.border_side), int'(cmd.local_y), int'(brd_pos));
    assign brd_wdata = (cmd.voxel_value != 8'd0);

    // Chunk edge flags of the held voxel
    assign x_lo = (x_reg == 4'd0);
    assign x_hi = (int'(x_reg) == CHUNK_W - 1);
    assign z_lo = (z_reg == 4'd0);
    assign z_hi = (int'(z_reg) == CHUNK_W - 1);
    assign y_lo = (y_reg == 7'd0);
    assign y_hi = (int'(y_reg) == CHUNK_H - 1);

    // Neighbor chunks inside the world bounds
    assign west_ok  = (int'(cfg.chunk_x) - 1) >= -int'(cfg.half_world);
    assign east_ok  = (int'(cfg.chunk_x) + 1) <  int'(cfg.half_world);
    assign north_ok = (int'(cfg.chunk_z) - 1) >= -int'(cfg.half_world);
    assign south_ok = (int'(cfg.chunk_z) + 1) <  int'(cfg.half_world);

    // Read address for the current step
    always_comb
    begin
        vox_raddr = vox_addr(int'(x_reg), int'(y_reg), int'(z_reg));
        brd_raddr = brd_addr(int'(vfcm_pkg::SIDE_WEST), int'(y_reg), int'(z_reg));
        case (step_reg)
            STEP_WEST:
            begin
                if (x_lo)
                    brd_raddr = brd_addr(int'(vfcm_pkg::SIDE_WEST), int'(y_reg), int'(z_reg));
                else
                    vox_raddr = vox_addr(int'(x_reg) - 1, int'(y_reg), int'(z_reg));
            end
            STEP_EAST:
            begin
                if (x_hi)
                    brd_raddr = brd_addr(int'(vfcm_pkg::SIDE_EAST), int'(y_reg), int'(z_reg));
                else
                    vox_raddr = vox_addr(int'(x_reg) + 1, int'(y_reg), int'(z_reg));
            end
            STEP_NORTH:
            begin
                if (z_lo)
                    brd_raddr = brd_addr(int'(vfcm_pkg::SIDE_NORTH), int'(y_reg), int'(x_reg));
                else
                    vox_raddr = vox_addr(int'(x_reg), int'(y_reg), int'(z_reg) - 1);
            end
            STEP_SOUTH:
            begin
                if (z_hi)
                    brd_raddr = brd_addr(int'(vfcm_pkg::SIDE_SOUTH), int'(y_reg), int'(x_reg));
                else
                    vox_raddr = vox_addr(int'(x_reg), int'(y_reg), int'(z_reg) + 1);
            end
            STEP_BOTTOM:
            begin
                if (!y_lo)
                    vox_raddr = vox_addr(int'(x_reg), int'(y_reg) - 1, int'(z_reg));
            end
            STEP_TOP:
            begin
                if (!y_hi)
                    vox_raddr = vox_addr(int'(x_reg), int'(y_reg) + 1, int'(z_reg));
            end
            default:
            begin
                vox_raddr = vox_addr(int'(x_reg), int'(y_reg), int'(z_reg));
            end
        endcase
    end

    // Decide the face of the direction whose read data arrives now
    assign dir = step_reg - 3'd2;
    always_comb
    begin
        case (dir)
            vfcm_pkg::DIR_WEST:   face_bit = x_lo ? (west_ok && !brd_rdata) : (vox_rdata == 8'd0);
            vfcm_pkg::DIR_EAST:   face_bit = x_hi ? (east_ok && !brd_rdata) : (vox_rdata == 8'd0);
            vfcm_pkg::DIR_NORTH:  face_bit = z_lo ? (north_ok && !brd_rdata) : (vox_rdata == 8'd0);
            vfcm_pkg::DIR_SOUTH:  face_bit = z_hi ? (south_ok && !brd_rdata) : (vox_rdata == 8'd0);
            vfcm_pkg::DIR_BOTTOM: face_bit = y_lo || (vox_rdata == 8'd0);
            vfcm_pkg::DIR_TOP:    face_bit = y_hi || (vox_rdata == 8'd0);
            default:              face_bit = 1'b0;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        id_next    = id_reg;
        mask_next  = mask_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.func == vfcm_pkg::FUNC_EXAMINE && in_range)
                begin
                    x_next     = cmd.local_x;
                    y_next     = cmd.local_y;
                    z_next     = cmd.local_z;
                    step_next  = STEP_CENTER;
                    mask_next  = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_WEST)
                    id_next = vox_rdata;
                if (step_reg >= STEP_EAST)
                    mask_next[dir] = face_bit;
                if (step_reg == STEP_DRAIN)
                begin
                    state_next = (id_reg != 8'd0 && mask_next != '0) ? S_HAND : S_IDLE;
                end
            end
            S_HAND:
            begin
                if (emit_idle)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hand the face mask to the emitter once it is free
    always_comb
    begin
        job.start = (state_reg == S_HAND) && emit_idle;
        job.mask  = mask_reg;
        job.id    = id_reg;
        job.x     = x_reg;
        job.y     = y_reg;
        job.z     = z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= STEP_CENTER;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        id_reg   <= id_next;
        mask_reg <= mask_next;
    end

endmodule

`default_nettype wire

// ----- design/vfcm_emit.sv -----
// Face emitter: walks a face mask, one face beat per cycle into the output
// register while not stalled; owns the vertex counter. Needs vfcm_pkg, vfcm_if.
`default_nettype none

module vfcm_emit #(
    parameter int CHUNK_W = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vfcm_pkg::vfcm_cfg_t cfg,
    input  wire vfcm_pkg::vfcm_job_t job,
    output logic                     emit_idle,
    vfcm_face_if.source              face
);

    logic        busy_reg, busy_next;
    logic [vfcm_pkg::NUM_DIRS-1:0] mask_reg, mask_next;
    logic [7:0]  id_reg;
    logic [3:0]  x_reg;
    logic [6:0]  y_reg;
    logic [3:0]  z_reg;
    logic [19:0] cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;

    logic signed [10:0] world_x_reg;
    logic [6:0]         world_y_reg;
    logic signed [10:0] world_z_reg;
    logic [2:0]         face_dir_reg;
    logic [7:0]         face_id_reg;
    logic [19:0]        first_vertex_reg;
    logic               last_reg;

    logic        load;
    logic [2:0]  pick;
    logic [vfcm_pkg::NUM_DIRS-1:0] remain;
    int          wx, wz;

    assign emit_idle = !busy_reg;
    assign load      = busy_reg && (!out_valid_reg || face.ready);

    // Lowest pending direction goes first
    always_comb
    begin
        pick = vfcm_pkg::DIR_WEST;
        for (int d = vfcm_pkg::NUM_DIRS - 1; d >= 0; d--)
        begin
            if (mask_reg[d])
                pick = 3'(d);
        end
    end

    always_comb
    begin
        remain       = mask_reg;
        remain[pick] = 1'b0;
    end

    assign wx = int'(cfg.chunk_x) * CHUNK_W + int'(x_reg);
    assign wz = int'(cfg.chunk_z) * CHUNK_W + int'(z_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        mask_next      = mask_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (face.ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            mask_next      = remain;
            busy_next      = (remain != '0);
            cnt_next       = cnt_reg + vfcm_pkg::VERTEX_STEP;
            out_valid_next = 1'b1;
        end
        else if (job.start)
        begin
            mask_next = job.mask;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
        end
    end

    // Latch the voxel of a new job
    always_ff @(posedge clk)
    begin
        if (job.start && !busy_reg)
        begin
            id_reg <= job.id;
            x_reg  <= job.x;
            y_reg  <= job.y;
            z_reg  <= job.z;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            world_x_reg      <= $signed(wx[10:0]);
            world_y_reg      <= y_reg;
            world_z_reg      <= $signed(wz[10:0]);
            face_dir_reg     <= pick;
            face_id_reg      <= id_reg;
            first_vertex_reg <= cnt_reg;
            last_reg         <= (remain == '0);
        end
    end

    assign face.valid         = out_valid_reg;
    assign face.world_x       = world_x_reg;
    assign face.world_y       = world_y_reg;
    assign face.world_z       = world_z_reg;
    assign face.face_dir      = face_dir_reg;
    assign face.face_voxel_id = face_id_reg;
    assign face.first_vertex  = first_vertex_reg;
    assign face.last          = last_reg;

endmodule

`default_nettype wire

// ----- design/voxel_face_culling_mesher_unit.sv -----
// Voxel face-culling mesher: top level with configuration registers, the two
// memories, the fetch sequencer and the face emitter.
// Depends on vfcm_pkg, vfcm_if, vfcm_ram, vfcm_scan and vfcm_emit.
//
// Usage:
//   cmd carries command beats: store a chunk voxel, store a neighbor border
//   cell, or examine one voxel. face carries one beat per visible face, with
//   last set on the final face of an examined voxel.
//   The config port (cfg_we, cfg_index, cfg_data) writes chunk_x, chunk_z and
//   half_world; write it only while no examine is in flight.
// Timing:
//   The memory write of a store beat lands on the accept edge. An examine
//   beat blocks cmd through the accept, seven reads of the voxel memory
//   (center and six neighbors, border memory in parallel at chunk edges), a
//   drain step and, for a solid voxel with faces, a hand-off that waits for
//   an idle emitter. The registered read port of the voxel memory makes the
//   drain step needed. The emitter latches the job, then registers the first
//   face; further faces follow one per cycle while the receiver takes them.
//   The emitter drains faces while the next command is fetched.
// Reset and stalls:
//   Reset clears control state, the vertex counter and the configuration
//   registers to their defaults; memory contents are undefined until written,
//   with no clearing pass. A stalled receiver holds the face register, and cmd
//   stays blocked once the emitter and the hand-off are both full.
`default_nettype none

module voxel_face_culling_mesher_unit #(
    parameter int CHUNK_W = 16,
    parameter int CHUNK_H = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    vfcm_cmd_if.sink        cmd,
    vfcm_face_if.source     face,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [6:0] cfg_data
);

    localparam int VOX_DEPTH = CHUNK_W * CHUNK_H * CHUNK_W;
    localparam int BRD_DEPTH = 4 * CHUNK_H * CHUNK_W;
    localparam int VAW       = $clog2(VOX_DEPTH);
    localparam int BAW       = $clog2(BRD_DEPTH);

    vfcm_pkg::vfcm_cfg_t cfg_reg, cfg_next;
    vfcm_pkg::vfcm_job_t job;
    logic                emit_idle;

    logic           vox_we;
    logic [VAW-1:0] vox_waddr, vox_raddr;
    logic [7:0]     vox_wdata, vox_rdata;
    logic           brd_we;
    logic [BAW-1:0] brd_waddr, brd_raddr;
    logic           brd_wdata, brd_rdata;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                vfcm_pkg::REG_CHUNK_X:    cfg_next.chunk_x    = $signed(cfg_data);
                vfcm_pkg::REG_CHUNK_Z:    cfg_next.chunk_z    = $signed(cfg_data);
                vfcm_pkg::REG_HALF_WORLD: cfg_next.half_world = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunk_x    <= '0;
            cfg_reg.chunk_z    <= '0;
            cfg_reg.half_world <= vfcm_pkg::HALF_WORLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vfcm_ram #(
        .WIDTH (8),
        .DEPTH (VOX_DEPTH)
    ) u_vox_ram (
        .clk   (clk),
        .we    (vox_we),
        .waddr (vox_waddr),
        .wdata (vox_wdata),
        .raddr (vox_raddr),
        .rdata (vox_rdata)
    );

    vfcm_ram #(
        .WIDTH (1),
        .DEPTH (BRD_DEPTH)
    ) u_brd_ram (
        .clk   (clk),
        .we    (brd_we),
        .waddr (brd_waddr),
        .wdata (brd_wdata),
        .raddr (brd_raddr),
        .rdata (brd_rdata)
    );

    vfcm_scan #(
        .CHUNK_W (CHUNK_W),
        .CHUNK_H (CHUNK_H)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .vox_we    (vox_we),
        .vox_waddr (vox_waddr),
        .vox_wdata (vox_wdata),
        .vox_raddr (vox_raddr),
        .vox_rdata (vox_rdata),
        .brd_we    (brd_we),
        .brd_waddr (brd_waddr),
        .brd_wdata (brd_wdata),
        .brd_raddr (brd_raddr),
        .brd_rdata (brd_rdata),
        .job       (job),
        .emit_idle (emit_idle)
    );

    vfcm_emit #(
        .CHUNK_W (CHUNK_W)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (job),
        .emit_idle (emit_idle),
        .face      (face)
    );

    // A face always belongs to a solid voxel
    assert property (@(posedge clk) disable iff (!rst_n)
        face.valid |-> (face.face_voxel_id != 8'd0))
    else $error("face beat with empty voxel id");

    // Faces of one voxel leave back to back when the receiver takes them
    assert property (@(posedge clk) disable iff (!rst_n)
        (face.valid && face.ready && !face.last) |=> face.valid)
    else $error("gap inside the faces of one voxel");

    // A voxel store beat never blocks the command channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.func == vfcm_pkg::FUNC_STORE_VOXEL) |=> cmd.ready)
    else $error("command channel blocked after a store");

    // A job is only handed over to an idle emitter with work in it
    assert property (@(posedge clk) disable iff (!rst_n)
        job.start |-> (emit_idle && job.mask != '0 && job.id != 8'd0))
    else $error("bad job hand-off");

endmodule

`default_nettype wire
